// File: src/coap_message_parser_defines.svh
// Assertion macros for the CoAP message parser checker.
// Every macro samples on clock; none depends on any other file.
`ifndef COAP_MESSAGE_PARSER_DEFINES_SVH
`define COAP_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define CMP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define CMP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define CMP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cmp_pkg.sv
// Shared types and codes for the CoAP message parser.
// No dependencies; the parser, parse core and checker all import this package.
package cmp_pkg;

   // Longest token that is parsed; longer ones discard the datagram
   localparam int unsigned MAX_TOKEN_LEN = 8;

   // Offsets added to extended option nibbles
   localparam logic [16:0] EXT8_OFFSET  = 17'd13;
   localparam logic [16:0] EXT16_OFFSET = 17'd269;

   localparam logic [7:0] MARKER_BYTE = 8'hFF;

   // Nibble codes of the option head
   localparam logic [3:0] NIB_EXT8    = 4'd13;
   localparam logic [3:0] NIB_RESERVED = 4'd15;

   // Extension progress codes
   localparam logic [1:0] EXT_NONE  = 2'd0;
   localparam logic [1:0] EXT_ONE   = 2'd1;
   localparam logic [1:0] EXT_TWO   = 2'd2;
   localparam logic [1:0] EXT_LOW   = 2'd3;

   // Byte kinds
   localparam logic [2:0] K_HEADER   = 3'd0;
   localparam logic [2:0] K_TOKEN    = 3'd1;
   localparam logic [2:0] K_OPT_HEAD = 3'd2;
   localparam logic [2:0] K_OPT_EXT  = 3'd3;
   localparam logic [2:0] K_VALUE    = 3'd4;
   localparam logic [2:0] K_MARKER   = 3'd5;
   localparam logic [2:0] K_PAYLOAD  = 3'd6;
   localparam logic [2:0] K_IGNORED  = 3'd7;

   // Error codes
   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_SHORT    = 3'd1;
   localparam logic [2:0] E_TOKEN    = 3'd2;
   localparam logic [2:0] E_DELTA    = 3'd3;
   localparam logic [2:0] E_LENGTH   = 3'd4;
   localparam logic [2:0] E_OVERFLOW = 3'd5;
   localparam logic [2:0] E_TRUNC    = 3'd6;

   // Parse phase, one-hot
   typedef enum logic [7:0] {
      PH_HEADER    = 8'b0000_0001,
      PH_TOKEN     = 8'b0000_0010,
      PH_OPT_HEAD  = 8'b0000_0100,
      PH_DELTA_EXT = 8'b0000_1000,
      PH_LEN_EXT   = 8'b0001_0000,
      PH_VALUE     = 8'b0010_0000,
      PH_PAYLOAD   = 8'b0100_0000,
      PH_DISCARD   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [1:0]  version;
      logic [1:0]  msg_type;
      logic [3:0]  token_len;
      logic [7:0]  code;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [16:0] option_length;
      logic [7:0]  data_byte;
      logic        end_of_message;
      logic [2:0]  error_code;
   } rsp_payload_type;

endpackage

// File: src/coap_message_parser.sv
// Top level of the CoAP message parser: input register, parse core, result register.
// Depends on cmp_pkg and cmp_parse_core.
//
//   channel  direction  handshake            beat
//   req      in         req_valid/req_ready  rx_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready  one tagged result per byte
//
// One byte per cycle sustained while rsp is not stalled; each accepted byte passes
// the input register, then the result register, before its result is valid.
// The parse state advances only when the input register moves into the result register.
// A stalled rsp holds its beat while the input register still takes one more byte.
// Synchronous reset clears both valid flags and returns the parser to the header phase.
module coap_message_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cmp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cmp_pkg::rsp_payload_type rsp_data
);
   import cmp_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type core_result;
   logic            fire;
   logic            req_accept;

   // Move a beat forward whenever the result register is free or being taken
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || fire;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   cmp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (in_data_ff),
      .result (core_result)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/cmp_parse_core.sv
// Parser state and per-byte next-state logic for the CoAP message parser.
// Depends on cmp_pkg for phase, kind and error codes and payload types.
module cmp_parse_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  cmp_pkg::req_payload_type item,
   output cmp_pkg::rsp_payload_type result
);
   import cmp_pkg::*;

   phase_type   phase_ff,      phase_in;
   logic [1:0]  hdr_cnt_ff,    hdr_cnt_in;
   logic [3:0]  token_left_ff, token_left_in;
   logic [1:0]  dext_ff,       dext_in;
   logic [1:0]  lext_ff,       lext_in;
   logic [7:0]  ext_acc_ff,    ext_acc_in;
   logic [15:0] run_opt_ff,    run_opt_in;
   logic [16:0] value_left_ff, value_left_in;
   logic [16:0] opt_len_ff,    opt_len_in;
   logic [1:0]  version_ff,    version_in;
   logic [1:0]  type_ff,       type_in;
   logic [3:0]  tlen_ff,       tlen_in;
   logic [7:0]  code_ff,       code_in;
   logic [15:0] msg_id_ff,     msg_id_in;
   logic [2:0]  err_ff,        err_in;

   logic [7:0]  b;
   logic [3:0]  dn;
   logic [3:0]  ln;
   logic [2:0]  kind;
   logic        marker_now;
   logic        add_en;
   logic [16:0] add_amt;
   logic [17:0] opt_sum;
   logic [16:0] vl_dec;
   logic [2:0]  err_mid;

   // Pick the phase that follows an option head or extension byte
   function automatic phase_type next_part(logic [1:0] dx, logic [1:0] lx, logic [16:0] vl);
      phase_type p;
      if (dx != EXT_NONE) begin
         p = PH_DELTA_EXT;
      end else if (lx != EXT_NONE) begin
         p = PH_LEN_EXT;
      end else if (vl != 17'd0) begin
         p = PH_VALUE;
      end else begin
         p = PH_OPT_HEAD;
      end
      return p;
   endfunction

   assign b  = item.rx_byte;
   assign dn = item.rx_byte[7:4];
   assign ln = item.rx_byte[3:0];
   assign vl_dec = (value_left_ff != 17'd0) ? value_left_ff - 17'd1 : value_left_ff;

   // Decode one byte against the current phase
   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      token_left_in = token_left_ff;
      dext_in       = dext_ff;
      lext_in       = lext_ff;
      ext_acc_in    = ext_acc_ff;
      run_opt_in    = run_opt_ff;
      value_left_in = value_left_ff;
      opt_len_in    = opt_len_ff;
      version_in    = version_ff;
      type_in       = type_ff;
      tlen_in       = tlen_ff;
      code_in       = code_ff;
      msg_id_in     = msg_id_ff;
      err_mid       = err_ff;
      kind          = K_IGNORED;
      marker_now    = 1'b0;
      add_en        = 1'b0;
      add_amt       = 17'd0;
      opt_sum       = 18'd0;
      err_in        = err_ff;

      unique case (phase_ff)
         PH_HEADER: begin
            kind = K_HEADER;
            unique case (hdr_cnt_ff)
               2'd0: begin
                  version_in = b[7:6];
                  type_in    = b[5:4];
                  tlen_in    = ln;
                  if ((ln > 4'(MAX_TOKEN_LEN)) && (err_mid == E_NONE)) begin
                     err_mid = E_TOKEN;
                  end
                  hdr_cnt_in = 2'd1;
               end
               2'd1: begin
                  code_in    = b;
                  hdr_cnt_in = 2'd2;
               end
               2'd2: begin
                  msg_id_in  = {b, 8'h00};
                  hdr_cnt_in = 2'd3;
               end
               default: begin
                  msg_id_in  = {msg_id_ff[15:8], b};
                  hdr_cnt_in = 2'd0;
                  if (tlen_ff > 4'(MAX_TOKEN_LEN)) begin
                     phase_in = PH_DISCARD;
                  end else if (tlen_ff != 4'd0) begin
                     token_left_in = tlen_ff;
                     phase_in      = PH_TOKEN;
                  end else begin
                     phase_in = PH_OPT_HEAD;
                  end
               end
            endcase
         end
         PH_TOKEN: begin
            kind          = K_TOKEN;
            token_left_in = token_left_ff - 4'd1;
            if (token_left_ff == 4'd1) begin
               phase_in = PH_OPT_HEAD;
            end
         end
         PH_OPT_HEAD: begin
            if (b == MARKER_BYTE) begin
               kind       = K_MARKER;
               marker_now = 1'b1;
               phase_in   = PH_PAYLOAD;
            end else begin
               kind = K_OPT_HEAD;
               if (dn == NIB_RESERVED) begin
                  if (err_mid == E_NONE) begin
                     err_mid = E_DELTA;
                  end
                  phase_in = PH_DISCARD;
               end else if (ln == NIB_RESERVED) begin
                  if (err_mid == E_NONE) begin
                     err_mid = E_LENGTH;
                  end
                  phase_in = PH_DISCARD;
               end else begin
                  // Short nibbles apply at once, 13 and 14 wait for extensions
                  if (dn < NIB_EXT8) begin
                     dext_in = EXT_NONE;
                     add_en  = 1'b1;
                     add_amt = {13'd0, dn};
                  end else begin
                     dext_in = (dn == NIB_EXT8) ? EXT_ONE : EXT_TWO;
                  end
                  if (ln < NIB_EXT8) begin
                     lext_in       = EXT_NONE;
                     value_left_in = {13'd0, ln};
                  end else begin
                     lext_in       = (ln == NIB_EXT8) ? EXT_ONE : EXT_TWO;
                     value_left_in = 17'd0;
                  end
                  opt_len_in = value_left_in;
                  phase_in   = next_part(dext_in, lext_in, value_left_in);
               end
            end
         end
         PH_DELTA_EXT: begin
            kind = K_OPT_EXT;
            if (dext_ff == EXT_TWO) begin
               ext_acc_in = b;
               dext_in    = EXT_LOW;
            end else begin
               add_en = 1'b1;
               if (dext_ff == EXT_LOW) begin
                  add_amt = {1'b0, ext_acc_ff, b} + EXT16_OFFSET;
               end else begin
                  add_amt = {9'd0, b} + EXT8_OFFSET;
               end
               dext_in    = EXT_NONE;
               ext_acc_in = 8'd0;
            end
            phase_in = next_part(dext_in, lext_ff, value_left_ff);
         end
         PH_LEN_EXT: begin
            kind = K_OPT_EXT;
            if (lext_ff == EXT_TWO) begin
               ext_acc_in = b;
               lext_in    = EXT_LOW;
            end else begin
               if (lext_ff == EXT_LOW) begin
                  value_left_in = {1'b0, ext_acc_ff, b} + EXT16_OFFSET;
               end else begin
                  value_left_in = {9'd0, b} + EXT8_OFFSET;
               end
               opt_len_in = value_left_in;
               lext_in    = EXT_NONE;
               ext_acc_in = 8'd0;
            end
            phase_in = next_part(dext_ff, lext_in, value_left_in);
         end
         PH_VALUE: begin
            kind          = K_VALUE;
            value_left_in = vl_dec;
            if (vl_dec == 17'd0) begin
               phase_in = PH_OPT_HEAD;
            end
         end
         PH_PAYLOAD: begin
            kind = K_PAYLOAD;
         end
         PH_DISCARD: begin
            kind = K_IGNORED;
         end
         default: begin
            kind = K_IGNORED;
         end
      endcase

      // Advance the running option number, saturating at the top
      if (add_en) begin
         opt_sum = {2'b00, run_opt_ff} + {1'b0, add_amt};
         if (opt_sum[17:16] != 2'b00) begin
            run_opt_in = 16'hFFFF;
            if (err_mid == E_NONE) begin
               err_mid = E_OVERFLOW;
            end
         end else begin
            run_opt_in = opt_sum[15:0];
         end
      end

      // Flag a datagram that ends early
      err_in = err_mid;
      if (item.last_byte && (err_mid == E_NONE)) begin
         if ((phase_in == PH_HEADER) && (hdr_cnt_in != 2'd0)) begin
            err_in = E_SHORT;
         end else if ((phase_in == PH_TOKEN) || (phase_in == PH_DELTA_EXT) ||
                      (phase_in == PH_LEN_EXT) || (phase_in == PH_VALUE) || marker_now) begin
            err_in = E_TRUNC;
         end
      end
   end

   // Build the result beat from the updated state
   always_comb begin
      result.byte_kind      = kind;
      result.version        = version_in;
      result.msg_type       = type_in;
      result.token_len      = tlen_in;
      result.code           = code_in;
      result.message_id     = msg_id_in;
      result.option_number  = run_opt_in;
      result.option_length  = opt_len_in;
      result.data_byte      = b;
      result.end_of_message = item.last_byte;
      result.error_code     = err_in;
   end

   // Hold state; drop back to the header phase after the last byte
   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= 2'd0;
         token_left_ff <= 4'd0;
         dext_ff       <= EXT_NONE;
         lext_ff       <= EXT_NONE;
         ext_acc_ff    <= 8'd0;
         run_opt_ff    <= 16'd0;
         value_left_ff <= 17'd0;
         opt_len_ff    <= 17'd0;
         version_ff    <= 2'd0;
         type_ff       <= 2'd0;
         tlen_ff       <= 4'd0;
         code_ff       <= 8'd0;
         msg_id_ff     <= 16'd0;
         err_ff        <= E_NONE;
      end else if (step) begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         token_left_ff <= token_left_in;
         dext_ff       <= dext_in;
         lext_ff       <= lext_in;
         ext_acc_ff    <= ext_acc_in;
         run_opt_ff    <= run_opt_in;
         value_left_ff <= value_left_in;
         opt_len_ff    <= opt_len_in;
         version_ff    <= version_in;
         type_ff       <= type_in;
         tlen_ff       <= tlen_in;
         code_ff       <= code_in;
         msg_id_ff     <= msg_id_in;
         err_ff        <= err_in;
      end
   end

endmodule

// File: src/cmp_checker.sv
// Port-level checks for the CoAP message parser, bound to the top level.
// Depends on cmp_pkg and coap_message_parser_defines.svh.
`include "coap_message_parser_defines.svh"

module cmp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input cmp_pkg::rsp_payload_type rsp_data
);
   import cmp_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   // Reset empties the result register
   `CMP_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "rsp_valid after reset")

   // A stalled result beat holds
   `CMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // A marker beat always carries the marker byte
   `CMP_ASSERT_NOW(a_marker_byte, rsp_valid && (rsp_data.byte_kind == K_MARKER),
      rsp_data.data_byte == MARKER_BYTE, "marker kind on non-marker byte")

   // Ignored bytes only follow a latched error
   `CMP_ASSERT_NOW(a_ignored_err, rsp_valid && (rsp_data.byte_kind == K_IGNORED),
      rsp_data.error_code != E_NONE, "ignored byte without error")

   // A result beat cannot appear in an empty result register without an earlier accepted byte
   `CMP_ASSERT_NEXT(a_no_invent, !rsp_valid && !req_seen,
      !rsp_valid || $past(rsp_valid) || $past(req_seen, 2), "result beat without a byte")

endmodule

bind coap_message_parser cmp_checker u_cmp_checker (.*);
